@@ hw/rtl/ppad_pkg.sv @@
package ppad_pkg;

  localparam int COORD_BITS_DEF   = 9;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF  = 2;

  localparam int DIST_W      = 10;
  localparam int CENTRE_W    = 9;
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_INDEX_W = 2;
  localparam int ANGLE_W     = 16;
  localparam int FRAC_SHIFT  = 24;
  localparam int Z_W         = 25;
  localparam int ATAN_LEN    = 24;
  localparam int ROUND_SHIFT = 9;
  localparam int ROUND_BIAS  = 256;
  localparam int LIMIT_OUT   = 23040;

  localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_DISTANCE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CENTRE_X       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CENTRE_Y       = 2'd2;

  localparam logic [DIST_W-1:0]   PLANE_DISTANCE_RST = 10'd242;
  localparam logic [CENTRE_W-1:0] CENTRE_X_RST       = 9'd160;
  localparam logic [CENTRE_W-1:0] CENTRE_Y_RST       = 9'd120;

  // 90 degrees with 16 fractional bits
  localparam logic signed [Z_W-1:0] DEG90 = 25'sd5898240;

  typedef enum logic [1:0] {
    KIND_CORDIC,
    KIND_ZERO,
    KIND_POS90,
    KIND_NEG90
  } ppad_kind_e;

  typedef struct packed {
    ppad_kind_e ref_kind;
    ppad_kind_e trk_kind;
  } ppad_class_t;

  // atan(2^-step) in degrees, 16 fractional bits
  function automatic logic signed [Z_W-1:0] ppad_atan(input int unsigned step);
    logic signed [Z_W-1:0] a;
    case (step)
      0:  a = 25'sd2949120;
      1:  a = 25'sd1740967;
      2:  a = 25'sd919879;
      3:  a = 25'sd466945;
      4:  a = 25'sd234379;
      5:  a = 25'sd117304;
      6:  a = 25'sd58666;
      7:  a = 25'sd29335;
      8:  a = 25'sd14668;
      9:  a = 25'sd7334;
      10: a = 25'sd3667;
      11: a = 25'sd1833;
      12: a = 25'sd917;
      13: a = 25'sd458;
      14: a = 25'sd229;
      15: a = 25'sd115;
      16: a = 25'sd57;
      17: a = 25'sd29;
      18: a = 25'sd14;
      19: a = 25'sd7;
      20: a = 25'sd4;
      21: a = 25'sd2;
      22: a = 25'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ hw/rtl/ppad_front.sv @@
module ppad_front #(
  parameter int COORD_BITS = 9,
  parameter int OFF_W      = 10
) (
  input  logic                          axis_select_i,
  input  logic [COORD_BITS-1:0]         reference_coord_i,
  input  logic [COORD_BITS-1:0]         tracked_coord_i,
  input  logic [ppad_pkg::DIST_W-1:0]   plane_distance_i,
  input  logic [ppad_pkg::CENTRE_W-1:0] centre_x_i,
  input  logic [ppad_pkg::CENTRE_W-1:0] centre_y_i,
  output logic signed [OFF_W-1:0]       ref_off_o,
  output logic signed [OFF_W-1:0]       trk_off_o,
  output ppad_pkg::ppad_class_t         class_o
);
  import ppad_pkg::*;

  logic [CENTRE_W-1:0] centre;
  logic                dist_zero;

  function automatic ppad_kind_e classify(input logic signed [OFF_W-1:0] off,
                                          input logic dz);
    ppad_kind_e k;
    if (off == '0) begin
      k = dz ? KIND_POS90 : KIND_ZERO;
    end else if (dz) begin
      k = off[OFF_W-1] ? KIND_NEG90 : KIND_POS90;
    end else begin
      k = KIND_CORDIC;
    end
    return k;
  endfunction

  assign centre    = axis_select_i ? centre_y_i : centre_x_i;
  assign dist_zero = (plane_distance_i == '0);

  assign ref_off_o = $signed(OFF_W'(reference_coord_i) - OFF_W'(centre));
  assign trk_off_o = $signed(OFF_W'(tracked_coord_i) - OFF_W'(centre));

  always_comb begin
    class_o.ref_kind = classify(ref_off_o, dist_zero);
    class_o.trk_kind = classify(trk_off_o, dist_zero);
  end

endmodule

@@ hw/rtl/ppad_queue.sv @@
module ppad_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ hw/rtl/ppad_back.sv @@
module ppad_back #(
  parameter int CORDIC_STEPS = 16,
  parameter int OFF_W        = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [ppad_pkg::DIST_W-1:0]        plane_distance_i,
  input  logic                               in_valid_i,
  input  logic signed [OFF_W-1:0]            ref_off_i,
  input  logic signed [OFF_W-1:0]            trk_off_i,
  input  ppad_pkg::ppad_class_t              class_i,
  output logic                               in_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [ppad_pkg::ANGLE_W-1:0] angle_o
);
  import ppad_pkg::*;

  localparam int N     = CORDIC_STEPS;
  localparam int MAG_W = (DIST_W > OFF_W - 1) ? DIST_W : OFF_W - 1;
  localparam int W     = MAG_W + 3 + FRAC_SHIFT;
  localparam int SUM_W = Z_W + 2;
  localparam int RND_W = SUM_W - ROUND_SHIFT;

  logic signed [W-1:0]   x_q [N+1][2];
  logic signed [W-1:0]   y_q [N+1][2];
  logic signed [Z_W-1:0] z_q [N+1][2];
  ppad_class_t           cls_q [N+1];
  logic [N:0]            valid_q;
  logic                  out_valid_q;
  logic signed [ANGLE_W-1:0] angle_q, angle_d;
  logic                  en;

  assign en          = !out_valid_q || out_ready_i;
  assign in_pop_o    = en && in_valid_i;
  assign out_valid_o = out_valid_q;
  assign angle_o     = angle_q;

  // stage 0 loads scaled vectors
  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0][0] <= W'(plane_distance_i) <<< FRAC_SHIFT;
      x_q[0][1] <= W'(plane_distance_i) <<< FRAC_SHIFT;
      y_q[0][0] <= W'(ref_off_i) <<< FRAC_SHIFT;
      y_q[0][1] <= W'(trk_off_i) <<< FRAC_SHIFT;
      z_q[0][0] <= '0;
      z_q[0][1] <= '0;
      cls_q[0]  <= class_i;
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_step
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [W-1:0]   dx, dy, x_d, y_d;
      logic signed [Z_W-1:0] z_d;
      always_comb begin
        dx = x_q[s][l] >>> s;
        dy = y_q[s][l] >>> s;
        if (!y_q[s][l][W-1]) begin
          x_d = x_q[s][l] + dy;
          y_d = y_q[s][l] - dx;
          z_d = z_q[s][l] + ppad_atan(s);
        end else begin
          x_d = x_q[s][l] - dy;
          y_d = y_q[s][l] + dx;
          z_d = z_q[s][l] - ppad_atan(s);
        end
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          x_q[s+1][l] <= x_d;
          y_q[s+1][l] <= y_d;
          z_q[s+1][l] <= z_d;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        cls_q[s+1] <= cls_q[s];
      end
    end
  end

  function automatic logic signed [Z_W-1:0] pick(input ppad_kind_e k,
                                                 input logic signed [Z_W-1:0] z);
    logic signed [Z_W-1:0] r;
    case (k)
      KIND_CORDIC: r = z;
      KIND_ZERO:   r = '0;
      KIND_POS90:  r = DEG90;
      KIND_NEG90:  r = -DEG90;
      default:     r = '0;
    endcase
    return r;
  endfunction

  // tracked minus reference, round to 1/128 degree, clamp
  always_comb begin
    logic signed [Z_W-1:0]   z_ref, z_trk;
    logic signed [SUM_W-1:0] sum;
    logic signed [RND_W-1:0] rnd;
    z_ref = pick(cls_q[N].ref_kind, z_q[N][0]);
    z_trk = pick(cls_q[N].trk_kind, z_q[N][1]);
    sum   = SUM_W'(z_trk) - SUM_W'(z_ref) + SUM_W'(ROUND_BIAS);
    rnd   = RND_W'(sum >>> ROUND_SHIFT);
    if (rnd > RND_W'(LIMIT_OUT)) begin
      angle_d = ANGLE_W'(LIMIT_OUT);
    end else if (rnd < -RND_W'(LIMIT_OUT)) begin
      angle_d = -ANGLE_W'(LIMIT_OUT);
    end else begin
      angle_d = ANGLE_W'(rnd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      valid_q     <= {valid_q[N-1:0], in_valid_i};
      out_valid_q <= valid_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      angle_q <= angle_d;
    end
  end

endmodule

@@ hw/rtl/pixel_pair_angle_difference.sv @@
// Angle difference of a pixel pair. Each transfer carries an axis select and a reference and
// a tracked coordinate on that axis; both are offset by the axis centre and turned into
// atan(offset / plane_distance) by a CORDIC, and the result is tracked angle minus reference
// angle in degrees times 128, rounded and clamped to +/-180 degrees. One pair is taken every
// clock cycle while the output is not stalled: the CORDIC is fully pipelined with one register
// stage per iteration, so a pair that leaves the input queue passes the load stage, every
// iteration register and the output register. A two-entry input queue and the output
// register let both sides stall on their own; while a result waits and pop is low the whole
// CORDIC pipeline holds.
// Configuration writes are always ready and must be made only while no pair is in flight.
module pixel_pair_angle_difference #(
  parameter int CORDIC_STEPS = ppad_pkg::CORDIC_STEPS_DEF,
  parameter int COORD_BITS   = ppad_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH  = ppad_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic                                axis_select_i,
  input  logic [COORD_BITS-1:0]               reference_coord_i,
  input  logic [COORD_BITS-1:0]               tracked_coord_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [ppad_pkg::ANGLE_W-1:0] angle_difference_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ppad_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [ppad_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ppad_pkg::*;

  localparam int OFF_W   = ((COORD_BITS > CENTRE_W) ? COORD_BITS : CENTRE_W) + 1;
  localparam int ENTRY_W = 2 * OFF_W + $bits(ppad_class_t);

  logic [DIST_W-1:0]   plane_distance_q;
  logic [CENTRE_W-1:0] centre_x_q, centre_y_q;

  logic signed [OFF_W-1:0] f_ref_off, f_trk_off, b_ref_off, b_trk_off;
  ppad_class_t             f_class, b_class;
  logic [ENTRY_W-1:0]      q_wdata, q_rdata;
  logic                    q_empty, q_pop, out_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_distance_q <= PLANE_DISTANCE_RST;
      centre_x_q       <= CENTRE_X_RST;
      centre_y_q       <= CENTRE_Y_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PLANE_DISTANCE: plane_distance_q <= cfg_data_i;
        CFG_CENTRE_X:       centre_x_q       <= cfg_data_i[CENTRE_W-1:0];
        CFG_CENTRE_Y:       centre_y_q       <= cfg_data_i[CENTRE_W-1:0];
        default:            ;
      endcase
    end
  end

  ppad_front #(
    .COORD_BITS(COORD_BITS),
    .OFF_W     (OFF_W)
  ) u_front (
    .axis_select_i    (axis_select_i),
    .reference_coord_i(reference_coord_i),
    .tracked_coord_i  (tracked_coord_i),
    .plane_distance_i (plane_distance_q),
    .centre_x_i       (centre_x_q),
    .centre_y_i       (centre_y_q),
    .ref_off_o        (f_ref_off),
    .trk_off_o        (f_trk_off),
    .class_o          (f_class)
  );

  assign q_wdata = {f_class, f_ref_off, f_trk_off};

  ppad_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(q_wdata),
    .full_o (full),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  assign b_class   = ppad_class_t'(q_rdata[ENTRY_W-1 -: $bits(ppad_class_t)]);
  assign b_ref_off = $signed(q_rdata[2*OFF_W-1 -: OFF_W]);
  assign b_trk_off = $signed(q_rdata[OFF_W-1:0]);

  ppad_back #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .OFF_W       (OFF_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .plane_distance_i(plane_distance_q),
    .in_valid_i      (!q_empty),
    .ref_off_i       (b_ref_off),
    .trk_off_i       (b_trk_off),
    .class_i         (b_class),
    .in_pop_o        (q_pop),
    .out_valid_o     (out_valid),
    .out_ready_i     (pop),
    .angle_o         (angle_difference_o)
  );

  assign empty = !out_valid;

  // results stay inside half a turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (angle_difference_o <= ANGLE_W'(LIMIT_OUT)) &&
               (angle_difference_o >= -ANGLE_W'(LIMIT_OUT)))
    else $error("angle difference out of range");

  // an idle back end always drains the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty && !q_empty |-> q_pop)
    else $error("back end stalled while output is free");

  // a queued pair with a waiting result and no pop stays queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |-> !q_pop)
    else $error("queue drained while pipeline held");

endmodule
